>>> hdl/mbt_pkg.sv
// types and constants shared by the boundary tracker
package mbt_pkg;

  // input beat: restart flag and one stream byte
  typedef struct packed {
    logic       restart;
    logic [7:0] data_byte;
  } in_t;

  // result beat
  typedef struct packed {
    logic        boundary_hit;
    logic [15:0] match_length;
    logic        boundary_known;
  } out_t;

  // phase codes
  localparam logic [1:0] PH_FIND  = 2'd0;
  localparam logic [1:0] PH_FOUND = 2'd1;
  localparam logic [1:0] PH_DELIM = 2'd2;

  // keyword position codes
  localparam logic [3:0] KP_IDLE  = 4'd0;
  localparam logic [3:0] KP_FIRST = 4'd1;
  localparam logic [3:0] KP_EQ    = 4'd9;
  localparam logic [3:0] KP_VAL   = 4'd10;

  // delimiter state codes
  localparam logic [2:0] DS_UNKNOWN = 3'd0;
  localparam logic [2:0] DS_CR      = 3'd1;
  localparam logic [2:0] DS_LF      = 3'd2;
  localparam logic [2:0] DS_HYP1    = 3'd3;
  localparam logic [2:0] DS_HYP2    = 3'd4;

  // character constants
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_HYPH  = 8'h2d;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // lower-case keyword letters, "boundary"
  localparam logic [7:0] KEYWORD [8] = '{8'h62, 8'h6f, 8'h75, 8'h6e,
                                         8'h64, 8'h61, 8'h72, 8'h79};

  // whitespace: sp, ht, lf, vt, ff, cr
  function automatic logic is_ws(input logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
  endfunction

endpackage

>>> hdl/mime_boundary_tracker.sv
// multipart boundary finder and body delimiter line tracker
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+----------------------------------
//  in      | in  | in_valid_i / in_ready_o | in_data_i  (restart, data_byte)
//  out     | out | out_valid_o/ out_ready_i| out_data_o (hit, length, known)
//
// one byte per cycle while the output register can take it; each byte's result appears in the output register on the
// cycle after it is taken, set by a single pass through the header and body logic.
// the value store is read one byte ahead of the body match position, so
// the stored byte to compare is ready when the next body byte arrives.
// reset clears all control state; the value store is not cleared.
// a new byte is taken whenever the output register is empty or being drained.
module mime_boundary_tracker #(
  parameter int MAX_VALUE_LEN = 70
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  mbt_pkg::in_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mbt_pkg::out_t out_data_o
);

  localparam int LW = $clog2(MAX_VALUE_LEN + 1);
  localparam int AW = (MAX_VALUE_LEN > 1) ? $clog2(MAX_VALUE_LEN) : 1;
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_VALUE_LEN);

  logic [1:0]    phase_q, phase_d;
  logic [3:0]    kp_q, kp_d;
  logic          quoted_q, quoted_d;
  logic [LW-1:0] vlen_q, vlen_d;
  logic [LW-1:0] tlen_q, tlen_d;
  logic [2:0]    ds_q, ds_d;
  logic [LW-1:0] mpos_q, mpos_d;
  logic [15:0]   run_q, run_d;
  logic          out_valid_q;
  mbt_pkg::out_t out_q, out_d;

  logic [7:0]    store_mem [MAX_VALUE_LEN];
  logic [7:0]    rd_q;
  logic          wr_en;
  logic          accept;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // next state for one byte
  always_comb begin
    logic [7:0] c;
    logic       ws;
    logic       done;
    logic       hit;
    logic       upd;
    logic [2:0] ds;
    logic [2:0] prev;
    logic [7:0] kch;
    c        = in_data_i.data_byte;
    ws       = mbt_pkg::is_ws(c);
    done     = 1'b0;
    hit      = 1'b0;
    upd      = 1'b0;
    ds       = mbt_pkg::DS_UNKNOWN;
    prev     = mbt_pkg::DS_UNKNOWN;
    kch      = mbt_pkg::KEYWORD[3'(kp_q - 4'd1)];
    wr_en    = 1'b0;
    phase_d  = phase_q;
    kp_d     = kp_q;
    quoted_d = quoted_q;
    vlen_d   = vlen_q;
    tlen_d   = tlen_q;
    ds_d     = ds_q;
    mpos_d   = mpos_q;
    run_d    = run_q;

    if (phase_q == mbt_pkg::PH_FIND) begin
      // header: keyword, '=', value capture
      if (kp_q == mbt_pkg::KP_IDLE || kp_q > mbt_pkg::KP_VAL) begin
        kp_d = (c == mbt_pkg::CH_DOT || ws) ? mbt_pkg::KP_FIRST : mbt_pkg::KP_IDLE;
      end else if (kp_q == mbt_pkg::KP_EQ) begin
        if (c == mbt_pkg::CH_EQ) kp_d = mbt_pkg::KP_VAL;
        else if (!ws) kp_d = mbt_pkg::KP_IDLE;
      end else if (kp_q == mbt_pkg::KP_VAL) begin
        if (vlen_q == '0 && !quoted_q && c == mbt_pkg::CH_QUOTE) begin
          quoted_d = 1'b1;
        end else if (quoted_q) begin
          if (c == mbt_pkg::CH_QUOTE || vlen_q >= MAX_LEN) begin
            vlen_d = tlen_q;
            done   = 1'b1;
          end else begin
            wr_en = 1'b1;
          end
        end else if (c == mbt_pkg::CH_SEMI || ws) begin
          done = (vlen_q != '0);
        end else if (vlen_q >= MAX_LEN) begin
          done = 1'b1;
        end else begin
          wr_en = 1'b1;
        end
        // append one value byte
        if (wr_en) begin
          vlen_d = vlen_q + LW'(1);
          if (!ws) tlen_d = vlen_q + LW'(1);
        end
      end else begin
        if (c == kch || c == (kch - mbt_pkg::CASE_OFS)) kp_d = kp_q + 4'd1;
        else kp_d = (c == mbt_pkg::CH_DOT || ws) ? mbt_pkg::KP_FIRST : mbt_pkg::KP_IDLE;
      end
      if (done) phase_d = mbt_pkg::PH_FOUND;
    end else if (phase_q == mbt_pkg::PH_FOUND || phase_q == mbt_pkg::PH_DELIM) begin
      // body: line break, two hyphens, stored value, newline
      ds   = (ds_q > mbt_pkg::DS_HYP2) ? mbt_pkg::DS_UNKNOWN : ds_q;
      prev = ds;
      upd  = 1'b1;
      case (ds)
        mbt_pkg::DS_UNKNOWN: begin
          if (c == mbt_pkg::CH_CR) ds = mbt_pkg::DS_CR;
          else if (c == mbt_pkg::CH_LF) ds = mbt_pkg::DS_LF;
          else if (c == mbt_pkg::CH_HYPH && phase_q == mbt_pkg::PH_FOUND)
            ds = mbt_pkg::DS_HYP1;
          else begin
            upd  = 1'b0;
            ds_d = mbt_pkg::DS_UNKNOWN;
          end
        end
        mbt_pkg::DS_CR: begin
          if (c == mbt_pkg::CH_LF) ds = mbt_pkg::DS_LF;
          else if (c == mbt_pkg::CH_CR) ds = mbt_pkg::DS_CR;
          else ds = mbt_pkg::DS_UNKNOWN;
        end
        mbt_pkg::DS_LF, mbt_pkg::DS_HYP1: begin
          if (c == mbt_pkg::CH_HYPH) begin
            if (ds == mbt_pkg::DS_HYP1) begin
              ds     = mbt_pkg::DS_HYP2;
              mpos_d = '0;
            end else begin
              ds = mbt_pkg::DS_HYP1;
            end
          end else if (c == mbt_pkg::CH_CR) ds = mbt_pkg::DS_CR;
          else if (c == mbt_pkg::CH_LF) ds = mbt_pkg::DS_LF;
          else ds = mbt_pkg::DS_UNKNOWN;
        end
        default: begin
          if (mpos_q >= vlen_q) begin
            if (c == mbt_pkg::CH_LF) begin
              if (run_q != '1) run_d = run_q + 16'd1;
              ds_d = mbt_pkg::DS_UNKNOWN;
              hit  = 1'b1;
              upd  = 1'b0;
            end else if (c != mbt_pkg::CH_CR && c != mbt_pkg::CH_HYPH &&
                         c != mbt_pkg::CH_SP && c != mbt_pkg::CH_HT) begin
              ds = mbt_pkg::DS_UNKNOWN;
            end
          end else if (mpos_q < MAX_LEN && rd_q == c) begin
            mpos_d = mpos_q + LW'(1);
          end else if (c == mbt_pkg::CH_CR) ds = mbt_pkg::DS_CR;
          else if (c == mbt_pkg::CH_LF) ds = mbt_pkg::DS_LF;
          else ds = mbt_pkg::DS_UNKNOWN;
        end
      endcase
      // candidate run count
      if (upd) begin
        ds_d = ds;
        if (ds == mbt_pkg::DS_UNKNOWN) run_d = '0;
        else if (prev >= ds && prev != mbt_pkg::DS_HYP2) run_d = 16'd1;
        else if (run_q != '1) run_d = run_q + 16'd1;
      end
      if (hit) phase_d = mbt_pkg::PH_DELIM;
    end

    out_d.boundary_hit   = hit;
    out_d.match_length   = run_d;
    out_d.boundary_known = (phase_d != mbt_pkg::PH_FIND);

    // restart drops everything
    if (in_data_i.restart) begin
      wr_en    = 1'b0;
      phase_d  = mbt_pkg::PH_FIND;
      kp_d     = mbt_pkg::KP_IDLE;
      quoted_d = 1'b0;
      vlen_d   = '0;
      tlen_d   = '0;
      ds_d     = mbt_pkg::DS_UNKNOWN;
      mpos_d   = '0;
      run_d    = '0;
      out_d    = '0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= mbt_pkg::PH_FIND;
      kp_q        <= mbt_pkg::KP_IDLE;
      quoted_q    <= 1'b0;
      vlen_q      <= '0;
      tlen_q      <= '0;
      ds_q        <= mbt_pkg::DS_UNKNOWN;
      mpos_q      <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q  <= phase_d;
        kp_q     <= kp_d;
        quoted_q <= quoted_d;
        vlen_q   <= vlen_d;
        tlen_q   <= tlen_d;
        ds_q     <= ds_d;
        mpos_q   <= mpos_d;
        run_q    <= run_d;
      end
      if (accept) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (accept) out_q <= out_d;
  end

  // value store; read data tracks the next body match position
  always_ff @(posedge clk_i) begin
    if (accept && wr_en) store_mem[vlen_q[AW-1:0]] <= in_data_i.data_byte;
    if (accept) begin
      if (mpos_d < MAX_LEN) rd_q <= store_mem[mpos_d[AW-1:0]];
    end else begin
      if (mpos_q < MAX_LEN) rd_q <= store_mem[mpos_q[AW-1:0]];
    end
  end

  // checks
  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vlen_q <= MAX_LEN)
    else $error("value length beyond cap");

  a_trim_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tlen_q <= vlen_q)
    else $error("trimmed length above value length");

  a_mpos_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mpos_q <= vlen_q)
    else $error("match position past stored value");

  a_hit_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.boundary_hit |-> out_q.boundary_known)
    else $error("hit reported before a boundary value was known");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.restart |=> phase_q == mbt_pkg::PH_FIND && run_q == '0
      && out_q == '0)
    else $error("restart did not clear state");

endmodule

>>> bench/mime_boundary_tracker_tb.sv
// self-checking bench for the multipart boundary tracker: byte stream in, per-byte status out
`timescale 1ns / 1ps

module mime_boundary_tracker_tb;

  localparam int VAL_MAX     = 70;
  localparam int RAND_HALF   = 280;
  localparam int PAD_LEN     = 30;
  localparam int QUIET_TAIL  = 100;
  localparam int IDLE_SPAN   = 40;
  localparam int HOLD_AT     = 200;
  localparam int HOLD_CYCLES = 100;
  localparam int STALL_LIMIT = 500;
  localparam int TAIL_CYCLES = 16;

  localparam logic [7:0] CH_VT = 8'h0b;
  localparam logic [7:0] CH_FF = 8'h0c;
  localparam logic [7:0] WS_SET [6]    = '{mbt_pkg::CH_SP, mbt_pkg::CH_HT, mbt_pkg::CH_LF,
                                           CH_VT, CH_FF, mbt_pkg::CH_CR};
  localparam logic [7:0] PAD_SET [4]   = '{mbt_pkg::CH_CR, mbt_pkg::CH_HYPH, mbt_pkg::CH_SP,
                                           mbt_pkg::CH_HT};
  localparam logic [7:0] BREAK_SET [3] = '{mbt_pkg::CH_CR, mbt_pkg::CH_LF, mbt_pkg::CH_HYPH};

  // one entry of the stimulus stream: a beat, or a pause until all results are back
  typedef struct packed {
    logic          drain;
    mbt_pkg::in_t  beat;
  } stim_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  mbt_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  mbt_pkg::out_t out_data;

  stim_t         stream_q [$];
  mbt_pkg::out_t result_due_q [$];
  int    stim_total = 0;
  int    restarts_sent = 0;
  int    in_count = 0;
  int    out_count = 0;
  int    errors = 0;
  int    hits_seen = 0;
  int    peak_len = 0;
  int    stall_cycles = 0;
  logic  quiet = 1'b0;

  // driver side
  bit    tx_took;
  bit    tx_idle_on = 1'b0;
  int    tx_gap = 0;
  int    tx_cyc = 0;
  stim_t tx_next;

  // receiver side
  bit            rx_idle_on = 1'b0;
  bit            hold_done = 1'b0;
  int            hold_left = 0;
  int            rx_gap = 0;
  int            rx_cyc = 0;
  mbt_pkg::out_t rx_want;

  // tracker state mirrored by the predictor
  logic [1:0]  trk_phase;
  logic [3:0]  trk_kw;
  logic        trk_quoted;
  logic [7:0]  trk_store [VAL_MAX];
  logic [6:0]  trk_len;
  logic [6:0]  trk_trim;
  logic [2:0]  trk_ds;
  logic [6:0]  trk_mpos;
  logic [15:0] trk_run;

  mime_boundary_tracker #(
    .MAX_VALUE_LEN(VAL_MAX)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic bit blank_char(logic [7:0] c);
    return c == mbt_pkg::CH_SP || c == mbt_pkg::CH_HT || c == mbt_pkg::CH_LF ||
           c == CH_VT || c == CH_FF || c == mbt_pkg::CH_CR;
  endfunction

  function automatic void clear_tracker();
    trk_phase  = mbt_pkg::PH_FIND;
    trk_kw     = mbt_pkg::KP_IDLE;
    trk_quoted = 1'b0;
    trk_len    = '0;
    trk_trim   = '0;
    trk_ds     = mbt_pkg::DS_UNKNOWN;
    trk_mpos   = '0;
    trk_run    = '0;
  endfunction

  // append to the captured value, trimmed length follows the last non-blank
  function automatic void keep_char(logic [7:0] c);
    if (trk_len < VAL_MAX) begin
      trk_store[trk_len] = c;
      trk_len = trk_len + 7'd1;
      if (!blank_char(c)) trk_trim = trk_len;
    end
  endfunction

  // header scan, returns 1 when the value is complete
  function automatic bit header_byte(logic [7:0] c);
    logic [7:0] k;
    bit         sep;
    sep = (c == mbt_pkg::CH_DOT) || blank_char(c);
    if (trk_kw == mbt_pkg::KP_IDLE || trk_kw > mbt_pkg::KP_VAL) begin
      trk_kw = sep ? mbt_pkg::KP_FIRST : mbt_pkg::KP_IDLE;
      return 1'b0;
    end
    if (trk_kw == mbt_pkg::KP_EQ) begin
      if (c == mbt_pkg::CH_EQ) trk_kw = mbt_pkg::KP_VAL;
      else if (!blank_char(c)) trk_kw = mbt_pkg::KP_IDLE;
      return 1'b0;
    end
    if (trk_kw == mbt_pkg::KP_VAL) begin
      if (trk_len == 0 && !trk_quoted && c == mbt_pkg::CH_QUOTE) begin
        trk_quoted = 1'b1;
        return 1'b0;
      end
      if (trk_quoted) begin
        if (c == mbt_pkg::CH_QUOTE || trk_len >= VAL_MAX) begin
          trk_len = trk_trim;
          return 1'b1;
        end
        keep_char(c);
        return 1'b0;
      end
      if (c == mbt_pkg::CH_SEMI || blank_char(c)) return trk_len != 0;
      if (trk_len >= VAL_MAX) return 1'b1;
      keep_char(c);
      return 1'b0;
    end
    // keyword letters, either case
    k = mbt_pkg::KEYWORD[3'(trk_kw - 4'd1)];
    if (c == k || c == k - mbt_pkg::CASE_OFS) trk_kw = trk_kw + 4'd1;
    else trk_kw = sep ? mbt_pkg::KP_FIRST : mbt_pkg::KP_IDLE;
    return 1'b0;
  endfunction

  // body scan, returns 1 on a delimiter line
  function automatic bit body_byte(logic [7:0] c);
    logic [2:0] ds;
    logic [2:0] prev;
    ds = (trk_ds > mbt_pkg::DS_HYP2) ? mbt_pkg::DS_UNKNOWN : trk_ds;
    prev = ds;
    case (ds)
      mbt_pkg::DS_UNKNOWN: begin
        if (c == mbt_pkg::CH_CR) ds = mbt_pkg::DS_CR;
        else if (c == mbt_pkg::CH_LF) ds = mbt_pkg::DS_LF;
        else if (c == mbt_pkg::CH_HYPH && trk_phase == mbt_pkg::PH_FOUND)
          ds = mbt_pkg::DS_HYP1;
        else begin
          trk_ds = mbt_pkg::DS_UNKNOWN;
          return 1'b0;
        end
      end
      mbt_pkg::DS_CR: begin
        ds = (c == mbt_pkg::CH_LF) ? mbt_pkg::DS_LF :
             (c == mbt_pkg::CH_CR) ? mbt_pkg::DS_CR : mbt_pkg::DS_UNKNOWN;
      end
      mbt_pkg::DS_LF, mbt_pkg::DS_HYP1: begin
        if (c == mbt_pkg::CH_HYPH) begin
          if (ds == mbt_pkg::DS_HYP1) begin
            ds = mbt_pkg::DS_HYP2;
            trk_mpos = '0;
          end else begin
            ds = mbt_pkg::DS_HYP1;
          end
        end else if (c == mbt_pkg::CH_CR) ds = mbt_pkg::DS_CR;
        else if (c == mbt_pkg::CH_LF) ds = mbt_pkg::DS_LF;
        else ds = mbt_pkg::DS_UNKNOWN;
      end
      default: begin
        if (trk_mpos >= trk_len) begin
          // full match, padding keeps it open until lf
          if (c == mbt_pkg::CH_LF) begin
            if (trk_run != 16'hFFFF) trk_run = trk_run + 16'd1;
            trk_ds = mbt_pkg::DS_UNKNOWN;
            return 1'b1;
          end
          if (c != mbt_pkg::CH_CR && c != mbt_pkg::CH_HYPH && c != mbt_pkg::CH_SP &&
              c != mbt_pkg::CH_HT) ds = mbt_pkg::DS_UNKNOWN;
        end else if (trk_mpos < VAL_MAX && trk_store[trk_mpos] == c) begin
          trk_mpos = trk_mpos + 7'd1;
        end else if (c == mbt_pkg::CH_CR) ds = mbt_pkg::DS_CR;
        else if (c == mbt_pkg::CH_LF) ds = mbt_pkg::DS_LF;
        else ds = mbt_pkg::DS_UNKNOWN;
      end
    endcase
    trk_ds = ds;
    // candidate run length
    if (ds == mbt_pkg::DS_UNKNOWN) trk_run = '0;
    else if (prev >= ds && prev != mbt_pkg::DS_HYP2) trk_run = 16'd1;
    else if (trk_run != 16'hFFFF) trk_run = trk_run + 16'd1;
    return 1'b0;
  endfunction

  // expected status for one accepted beat
  function automatic mbt_pkg::out_t track_byte(mbt_pkg::in_t b);
    mbt_pkg::out_t r;
    bit            hit;
    hit = 1'b0;
    if (b.restart) begin
      clear_tracker();
      return '0;
    end
    if (trk_phase == mbt_pkg::PH_FIND) begin
      if (header_byte(b.data_byte)) trk_phase = mbt_pkg::PH_FOUND;
    end else if (trk_phase == mbt_pkg::PH_FOUND || trk_phase == mbt_pkg::PH_DELIM) begin
      if (body_byte(b.data_byte)) begin
        trk_phase = mbt_pkg::PH_DELIM;
        hit = 1'b1;
      end
    end
    r.boundary_hit   = hit;
    r.match_length   = trk_run;
    r.boundary_known = (trk_phase != mbt_pkg::PH_FIND);
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic put_beat(mbt_pkg::in_t b);
    stim_t s;
    s.drain = 1'b0;
    s.beat  = b;
    stream_q.push_back(s);
    stim_total++;
    if (b.restart) restarts_sent++;
  endtask

  task automatic put_byte(logic [7:0] c);
    mbt_pkg::in_t b;
    b.restart   = 1'b0;
    b.data_byte = c;
    put_beat(b);
  endtask

  task automatic put_restart(logic [7:0] c);
    mbt_pkg::in_t b;
    b.restart   = 1'b1;
    b.data_byte = c;
    put_beat(b);
  endtask

  task automatic put_text(string t);
    for (int i = 0; i < t.len(); i++) put_byte(t[i]);
  endtask

  task automatic put_drain();
    stim_t s;
    s = '0;
    s.drain = 1'b1;
    stream_q.push_back(s);
  endtask

  // value character: printable or high byte, never a quote or semicolon
  function automatic logic [7:0] token_char();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 255));
    while (c == mbt_pkg::CH_QUOTE || c == mbt_pkg::CH_SEMI);
    return c;
  endfunction

  // random bytes with the odd restart
  task automatic gen_noise();
    mbt_pkg::in_t b;
    repeat ($urandom_range(5, 20)) begin
      b.data_byte = 8'($urandom);
      b.restart = ($urandom_range(0, 15) == 0);
      put_beat(b);
    end
  endtask

  // header with a boundary value, then body lines around that delimiter
  task automatic gen_message();
    logic [7:0] vtext [$];
    logic [7:0] val [$];
    logic [7:0] c;
    int         i;
    int         vlen;
    int         kind;
    int         pos;
    bit         quote_it;
    put_restart(8'($urandom_range(0, 255)));
    // leading junk and separator, or keyword right at stream start
    if ($urandom_range(0, 11) != 0) begin
      repeat ($urandom_range(0, 5)) put_byte(8'($urandom_range(0, 255)));
      put_byte(($urandom_range(0, 6) == 6) ? mbt_pkg::CH_DOT : WS_SET[$urandom_range(0, 5)]);
    end
    // keyword, mixed case, sometimes misspelled
    pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : -1;
    for (i = 0; i < 8; i++) begin
      c = mbt_pkg::KEYWORD[i];
      if ($urandom_range(0, 1)) c = c - mbt_pkg::CASE_OFS;
      if (i == pos) c = c + 8'd1;
      put_byte(c);
    end
    repeat ($urandom_range(0, 2)) put_byte(WS_SET[$urandom_range(0, 5)]);
    put_byte(($urandom_range(0, 11) == 0) ? token_char() : mbt_pkg::CH_EQ);
    // value text, mostly short, sometimes past the cap, sometimes empty
    kind = $urandom_range(0, 15);
    vlen = (kind == 0) ? $urandom_range(66, 76) : (kind == 1) ? 0 : $urandom_range(1, 12);
    quote_it = ($urandom_range(0, 2) == 0);
    for (i = 0; i < vlen; i++) begin
      if (quote_it && $urandom_range(0, 4) == 0) vtext.push_back(WS_SET[$urandom_range(0, 5)]);
      else vtext.push_back(token_char());
    end
    if (quote_it) repeat ($urandom_range(0, 2)) vtext.push_back(mbt_pkg::CH_SP);
    for (i = 0; i < vtext.size() && i < VAL_MAX; i++) val.push_back(vtext[i]);
    if (quote_it) begin
      put_byte(mbt_pkg::CH_QUOTE);
      while (val.size() > 0 && blank_char(val[val.size() - 1])) void'(val.pop_back());
      vtext.push_back(mbt_pkg::CH_QUOTE);
    end else begin
      repeat ($urandom_range(0, 2)) put_byte(WS_SET[$urandom_range(0, 5)]);
      vtext.push_back($urandom_range(0, 1) ? mbt_pkg::CH_SEMI : WS_SET[$urandom_range(0, 5)]);
    end
    foreach (vtext[j]) put_byte(vtext[j]);
    // body lines: text, delimiters, broken delimiters, break soup
    repeat ($urandom_range(2, 6)) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        repeat ($urandom_range(0, 8)) put_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) put_byte(mbt_pkg::CH_CR);
        put_byte(mbt_pkg::CH_LF);
      end else if (kind == 9) begin
        repeat ($urandom_range(1, 6)) put_byte(BREAK_SET[$urandom_range(0, 2)]);
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            put_byte(mbt_pkg::CH_CR);
            put_byte(mbt_pkg::CH_LF);
          end
          1: put_byte(mbt_pkg::CH_LF);
          default: ;
        endcase
        put_byte(mbt_pkg::CH_HYPH);
        put_byte(mbt_pkg::CH_HYPH);
        pos = (kind >= 7) ? $urandom_range(0, val.size()) : -1;
        foreach (val[j]) begin
          if (j == pos) begin
            case ($urandom_range(0, 2))
              0: put_byte(mbt_pkg::CH_CR);
              1: put_byte(mbt_pkg::CH_LF);
              default: put_byte(8'($urandom_range(0, 255)));
            endcase
          end else begin
            put_byte(val[j]);
          end
        end
        if (pos == val.size()) put_byte(token_char());
        repeat ($urandom_range(0, 3)) put_byte(PAD_SET[$urandom_range(0, 3)]);
        if ($urandom_range(0, 7) == 0) put_byte(token_char());
        if ($urandom_range(0, 1)) put_byte(mbt_pkg::CH_CR);
        put_byte(mbt_pkg::CH_LF);
      end
    end
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      tx_took = in_valid && in_ready;
      if (tx_took) begin
        result_due_q.push_back(track_byte(in_data));
        in_count <= in_count + 1;
      end
      if (tx_cyc % IDLE_SPAN == 0) tx_idle_on = ($urandom_range(0, 2) != 0);
      tx_cyc++;
      quiet <= (stream_q.size() < QUIET_TAIL);
      // pick what to offer next once the current beat is gone
      if (tx_took || !in_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (stream_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (stream_q[0].drain) begin
          if (!tx_took && in_count == out_count) stream_q.delete(0);
          in_valid <= 1'b0;
        end else if (tx_idle_on && !quiet && $urandom_range(0, 5) == 0) begin
          tx_gap = $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else begin
          tx_next = stream_q.pop_front();
          in_valid <= 1'b1;
          in_data  <= tx_next.beat;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic flag_field(string name, int unsigned want, int unsigned got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_count <= out_count + 1;
        if (result_due_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, expected none, actual %h",
                   $time, out_data);
        end else begin
          rx_want = result_due_q.pop_front();
          if (out_data.boundary_hit !== rx_want.boundary_hit)
            flag_field("boundary_hit", 32'(rx_want.boundary_hit),
                       32'(out_data.boundary_hit));
          if (out_data.match_length !== rx_want.match_length)
            flag_field("match_length", 32'(rx_want.match_length),
                       32'(out_data.match_length));
          if (out_data.boundary_known !== rx_want.boundary_known)
            flag_field("boundary_known", 32'(rx_want.boundary_known),
                       32'(out_data.boundary_known));
        end
        if (out_data.boundary_hit === 1'b1) hits_seen++;
        if (int'(out_data.match_length) > peak_len) peak_len = int'(out_data.match_length);
      end
      if (rx_cyc % IDLE_SPAN == 0) rx_idle_on = ($urandom_range(0, 2) != 0);
      rx_cyc++;
      // ready: one long hold-off, then short random bursts
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && in_count >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else if (rx_idle_on && !quiet && $urandom_range(0, 4) == 0) begin
        rx_gap = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, stall_cycles);
        $display("Test completed with failures");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int mark;
    clear_tracker();
    // directed: restart, byte extremes, keyword at stream start, empty quoted value
    put_restart(8'hFF);
    put_text("boundary;");
    put_byte(8'h00);
    put_byte(8'hFF);
    put_text("\tBOUNDARY=\"\"");
    put_text("\n--\n");
    // random messages and noise
    mark = stim_total;
    while (stim_total - mark < RAND_HALF) begin
      if ($urandom_range(0, 9) == 0) gen_noise();
      else gen_message();
    end
    put_drain();
    // padding after a full match keeps the candidate open and the run count growing
    put_restart(8'($urandom_range(0, 255)));
    put_text(" boundary=ab\r\n--ab");
    repeat (PAD_LEN) put_byte(PAD_SET[$urandom_range(0, 3)]);
    put_text("\n\r\n--ab\n");
    mark = stim_total;
    while (stim_total - mark < RAND_HALF) begin
      if ($urandom_range(0, 9) == 0) gen_noise();
      else gen_message();
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (in_count != stim_total || out_count != stim_total) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (result_due_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results still expected, actual none", $time, result_due_q.size());
    end
    $display("covered %0d beats with %0d restarts, %0d delimiter hits, peak run length %0d",
             stim_total, restarts_sent, hits_seen, peak_len);
    $display("long output hold-off and a full drain pause were exercised, %0d errors", errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
